[rtl/abdc_pkg.sv]
// ----------------------------------------------------------------------------
// abdc_pkg: shared constants, types and tables of the anchor box decoder
// Fixed-point formats, register indexes, the 2^x mantissa table and the
// image clip bound function.
// ----------------------------------------------------------------------------
package abdc_pkg;

	// Feature map coordinates use only the low GRID_DIM_BITS of the 10-bit fields.
	localparam int GRID_DIM_BITS  = 10;
	localparam int GRID_FIELD_W   = 10;
	localparam logic [GRID_FIELD_W-1:0] GRID_MASK = GRID_FIELD_W'((64'd1 << GRID_DIM_BITS) - 64'd1);

	// Exponential: table of 2^(i/2^EXP_TABLE_BITS) with linear interpolation.
	localparam int EXP_TABLE_BITS = 6;
	localparam int EXP_TAB_SIZE   = 1 << EXP_TABLE_BITS;
	localparam int EXP_LOW_BITS   = 16 - EXP_TABLE_BITS;
	localparam int POW2_W         = 18;
	localparam int EXP_W          = 28;
	localparam int EXP_K_W        = 5;
	localparam int EXP_SHL_W      = POW2_W + (1 << (EXP_K_W - 1));
	localparam longint unsigned LN2_Q30 = 64'd744261118;
	localparam logic signed [15:0] LOG2E_Q14 = 16'sd23637;
	localparam logic [EXP_W-1:0] EXP_SAT = {EXP_W{1'b1}};

	// Datapath widths: centre in Q.21, sums of centre and half extent.
	localparam int AW_W  = 22;
	localparam int AX_W  = 23;
	localparam int CW    = 48;
	localparam int SW    = 54;
	localparam int COORD_W = 17;
	localparam logic [COORD_W-1:0] COORD_MAX = {COORD_W{1'b1}};

	// Configuration port.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 17;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_BOX_SIZE   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FEATURE_STRIDE = 2'd3;

	typedef logic [POW2_W-1:0] pow2_tab_t [0:EXP_TAB_SIZE];

	typedef struct packed {
		logic [15:0] score;
		logic        last;
	} meta_t;

	// Shift-and-subtract quotient used while the table is built.
	function automatic longint unsigned series_div(longint unsigned num,
		longint unsigned den);
		longint unsigned quo;
		longint unsigned part;
		quo = '0;
		part = '0;
		for (int i = 63; i >= 0; i--) begin
			part = {part[62:0], num[i]};
			quo = quo << 1;
			if (part >= den) begin
				part = part - den;
				quo[0] = 1'b1;
			end
		end
		return quo;
	endfunction

	// Each entry is a 14-term series of exp(i*ln2/2^B) in Q.30, rounded to Q.16.
	function automatic pow2_tab_t build_pow2_tab();
		pow2_tab_t tab;
		longint unsigned z;
		longint unsigned term;
		longint unsigned sum;
		for (int i = 0; i <= EXP_TAB_SIZE; i++) begin
			z = (longint'(i) * LN2_Q30) >> EXP_TABLE_BITS;
			term = 64'd1 << 30;
			sum = term;
			for (int n = 1; n <= 13; n++) begin
				term = series_div((term * z) >> 30, 64'(n));
				sum = sum + term;
			end
			tab[i] = POW2_W'((sum + (64'd1 << 13)) >> 14);
		end
		return tab;
	endfunction

	localparam pow2_tab_t POW2_TAB = build_pow2_tab();

	// Largest clipped coordinate in Q.4; a zero size acts as one.
	function automatic logic [COORD_W-1:0] clip_bound(logic [13:0] size);
		logic [18:0] b;
		b = {1'b0, size - 14'd1, 4'b0};
		if (size == 14'd0) return '0;
		if (b > 19'(COORD_MAX)) return COORD_MAX;
		return b[COORD_W-1:0];
	endfunction

endpackage

[rtl/abdc_if.sv]
// ----------------------------------------------------------------------------
// abdc_if: proposal and box channels
// Valid/ready channels carrying one proposal or one decoded box per transaction.
// ----------------------------------------------------------------------------
interface abdc_in_if;
	logic               valid;
	logic               ready;
	logic signed [19:0] anchor_left;
	logic signed [19:0] anchor_top;
	logic signed [19:0] anchor_right;
	logic signed [19:0] anchor_bottom;
	logic [9:0]         grid_col;
	logic [9:0]         grid_row;
	logic [15:0]        objectness;
	logic signed [15:0] delta_x;
	logic signed [15:0] delta_y;
	logic signed [15:0] delta_w;
	logic signed [15:0] delta_h;
	logic               last_in;

	modport source (output valid, anchor_left, anchor_top, anchor_right, anchor_bottom,
		grid_col, grid_row, objectness, delta_x, delta_y, delta_w, delta_h, last_in,
		input ready);
	modport sink (input valid, anchor_left, anchor_top, anchor_right, anchor_bottom,
		grid_col, grid_row, objectness, delta_x, delta_y, delta_w, delta_h, last_in,
		output ready);
endinterface

interface abdc_out_if;
	logic        valid;
	logic        ready;
	logic [16:0] box_left;
	logic [16:0] box_top;
	logic [16:0] box_right;
	logic [16:0] box_bottom;
	logic [15:0] score_out;
	logic        keep;
	logic        last_out;

	modport source (output valid, box_left, box_top, box_right, box_bottom, score_out,
		keep, last_out, input ready);
	modport sink (input valid, box_left, box_top, box_right, box_bottom, score_out,
		keep, last_out, output ready);
endinterface

[rtl/abdc_exp.sv]
// ----------------------------------------------------------------------------
// abdc_exp: pipelined saturating exponential
// exp of a Q4.12 delta as an unsigned Q.16 value, four register stages.
// ----------------------------------------------------------------------------
module abdc_exp import abdc_pkg::*; (
	input  logic               clk,
	input  logic               en,
	input  logic signed [15:0] d,
	output logic [EXP_W-1:0]   e
);

	logic signed [30:0]          prod_s1;
	logic signed [20:0]          y;
	logic [EXP_TABLE_BITS-1:0]   idx;
	logic [POW2_W-1:0]           t0, t1;
	logic signed [EXP_K_W-1:0]   k_s2, k_s3;
	logic [POW2_W-1:0]           t0_s2, dt_s2, m_s3;
	logic [EXP_LOW_BITS-1:0]     rem_s2;
	logic [POW2_W+EXP_LOW_BITS-1:0] step;
	logic [EXP_SHL_W-1:0]        r;
	logic [EXP_W-1:0]            e_s4;

	// Stage 2 splits y = d*log2(e) in Q.16 into integer and fraction.
	assign y   = 21'(prod_s1 >>> 10);
	assign idx = y[15:EXP_LOW_BITS];
	assign t0  = POW2_TAB[idx];
	assign t1  = POW2_TAB[(EXP_TABLE_BITS+1)'(idx) + (EXP_TABLE_BITS+1)'(1)];
	assign step = (POW2_W+EXP_LOW_BITS)'(dt_s2) * (POW2_W+EXP_LOW_BITS)'(rem_s2);

	always_comb begin
		if (k_s3 < 0) begin
			r = EXP_SHL_W'(m_s3 >> (-k_s3));
		end else begin
			r = EXP_SHL_W'(m_s3) << k_s3[EXP_K_W-2:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= 31'(d) * 31'(LOG2E_Q14);
			k_s2    <= y[20:16];
			t0_s2   <= t0;
			dt_s2   <= t1 - t0;
			rem_s2  <= y[EXP_LOW_BITS-1:0];
			k_s3    <= k_s2;
			m_s3    <= t0_s2 + POW2_W'(step >> EXP_LOW_BITS);
			e_s4    <= (r > EXP_SHL_W'(EXP_SAT)) ? EXP_SAT : r[EXP_W-1:0];
		end
	end

	assign e = e_s4;

endmodule

[rtl/abdc_clip.sv]
// ----------------------------------------------------------------------------
// abdc_clip: corner rounding and clipping
// Forms both corners of one axis from centre and half extent, rounds Q.21
// to Q.4 and clamps to the image; one register stage.
// ----------------------------------------------------------------------------
module abdc_clip import abdc_pkg::*; (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [CW-1:0] c,
	input  logic signed [SW-1:0] h,
	input  logic [COORD_W-1:0]   bound,
	output logic [COORD_W-1:0]   lo,
	output logic [COORD_W-1:0]   hi
);

	logic [COORD_W-1:0] lo_s6, hi_s6;

	function automatic logic [COORD_W-1:0] round_clamp(logic signed [SW-1:0] v,
		logic [COORD_W-1:0] b);
		logic signed [SW-1:0] q;
		q = (v + SW'(65536)) >>> 17;
		if (q < 0) return '0;
		if (q > $signed({{(SW-COORD_W){1'b0}}, b})) return b;
		return q[COORD_W-1:0];
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			lo_s6 <= round_clamp(SW'(c) - h, bound);
			hi_s6 <= round_clamp(SW'(c) + h, bound);
		end
	end

	assign lo = lo_s6;
	assign hi = hi_s6;

endmodule

[rtl/anchor_box_decode_clip.sv]
// ----------------------------------------------------------------------------
// anchor_box_decode_clip: region-proposal box decoder with image clipping
// Decodes regression deltas against grid-shifted anchors into clipped boxes.
// ----------------------------------------------------------------------------
// Usage: proposals arrive on the valid/ready channel "proposal", one per
// transaction, and leave as decoded boxes on the channel "box" in the same
// order, one box per proposal. The block is a seven-stage pipeline that
// includes the four-stage exponential unit; while the receiver does not
// stall, one proposal can be taken in every cycle, so the sustained rate is
// one transaction per cycle.
// When the receiver stalls with a box waiting, the whole pipeline holds and
// proposal.ready drops in the same cycle; when the output stage is empty the
// pipeline keeps moving, so bubbles are filled. Nothing is dropped or repeated.
// The configuration port takes image height, image width, minimum box size
// and feature stride by register index; writes are registered and must be
// made while no proposal is in flight.
// Reset clears all valid bits and loads the registers with 1024, 1024, 256
// and 16; no clearing pass is needed.
// ----------------------------------------------------------------------------
module anchor_box_decode_clip import abdc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	abdc_in_if.sink               proposal,
	abdc_out_if.source            box
);

	// Configuration registers.
	logic [13:0] image_height_q;
	logic [13:0] image_width_q;
	logic [16:0] min_box_size_q;
	logic [6:0]  feature_stride_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_height_q   <= 14'd1024;
			image_width_q    <= 14'd1024;
			min_box_size_q   <= 17'd256;
			feature_stride_q <= 7'd16;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_IMAGE_HEIGHT:   image_height_q   <= cfg_wdata[13:0];
				REG_IMAGE_WIDTH:    image_width_q    <= cfg_wdata[13:0];
				REG_MIN_BOX_SIZE:   min_box_size_q   <= cfg_wdata[16:0];
				REG_FEATURE_STRIDE: feature_stride_q <= cfg_wdata[6:0];
				default: ;
			endcase
		end
	end

	// The pipeline advances as a whole whenever the output stage can move.
	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;

	assign en = box.ready || !v_s7;
	assign proposal.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s1 <= proposal.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// Stage 1: anchor size and grid-shifted anchor origin, both in Q.4.
	logic [9:0]  col, row;
	logic [10:0] stride16;
	logic [20:0] offx, offy;
	logic signed [AW_W-1:0] aw_s1, ah_s1, aw_s2, ah_s2, aw_s3, ah_s3, aw_s4, ah_s4;
	logic signed [AX_W-1:0] ax_s1, ay_s1;
	logic signed [15:0]     dx_s1, dy_s1;
	meta_t meta_s1, meta_s2, meta_s3, meta_s4, meta_s5, meta_s6, meta_s7;

	assign col      = proposal.grid_col & GRID_MASK;
	assign row      = proposal.grid_row & GRID_MASK;
	assign stride16 = {feature_stride_q, 4'b0};
	assign offx     = 21'(col) * 21'(stride16);
	assign offy     = 21'(row) * 21'(stride16);

	// Stage 2: centre in Q.21 from the anchor centre plus size times delta.
	logic signed [24:0]   basex, basey;
	logic signed [37:0]   awdx, ahdy;
	logic signed [CW-1:0] cx_s2, cy_s2, cx_s3, cy_s3, cx_s4, cy_s4, cx_s5, cy_s5;

	assign basex = 25'(ax_s1) + 25'(ax_s1) + 25'(aw_s1) - 25'sd16;
	assign basey = 25'(ay_s1) + 25'(ay_s1) + 25'(ah_s1) - 25'sd16;
	assign awdx  = 38'(aw_s1) * 38'(dx_s1);
	assign ahdy  = 38'(ah_s1) * 38'(dy_s1);

	// Stages 1 to 4: the exponentials of the size deltas.
	logic [EXP_W-1:0] ew, eh;

	abdc_exp u_exp_w (.clk(clk), .en(en), .d(proposal.delta_w), .e(ew));
	abdc_exp u_exp_h (.clk(clk), .en(en), .d(proposal.delta_h), .e(eh));

	// Stage 5: half extent minus half a pixel, (size - 1) / 2 in Q.21.
	logic signed [50:0]   awe, ahe;
	logic signed [SW-1:0] hw_s5, hh_s5;

	assign awe = 51'(aw_s4) * 51'(signed'({1'b0, ew}));
	assign ahe = 51'(ah_s4) * 51'(signed'({1'b0, eh}));

	always_ff @(posedge clk) begin
		if (en) begin
			aw_s1   <= AW_W'(proposal.anchor_right) - AW_W'(proposal.anchor_left) + 22'sd16;
			ah_s1   <= AW_W'(proposal.anchor_bottom) - AW_W'(proposal.anchor_top) + 22'sd16;
			ax_s1   <= AX_W'(proposal.anchor_left) + signed'({2'b0, offx});
			ay_s1   <= AX_W'(proposal.anchor_top) + signed'({2'b0, offy});
			dx_s1   <= proposal.delta_x;
			dy_s1   <= proposal.delta_y;
			meta_s1 <= '{score: proposal.objectness, last: proposal.last_in};

			cx_s2   <= (CW'(basex) <<< 16) + (CW'(awdx) <<< 5);
			cy_s2   <= (CW'(basey) <<< 16) + (CW'(ahdy) <<< 5);
			aw_s2   <= aw_s1;
			ah_s2   <= ah_s1;
			meta_s2 <= meta_s1;

			cx_s3   <= cx_s2;
			cy_s3   <= cy_s2;
			aw_s3   <= aw_s2;
			ah_s3   <= ah_s2;
			meta_s3 <= meta_s2;

			cx_s4   <= cx_s3;
			cy_s4   <= cy_s3;
			aw_s4   <= aw_s3;
			ah_s4   <= ah_s3;
			meta_s4 <= meta_s3;

			cx_s5   <= cx_s4;
			cy_s5   <= cy_s4;
			hw_s5   <= SW'(awe) - SW'(64'd1048576);
			hh_s5   <= SW'(ahe) - SW'(64'd1048576);
			meta_s5 <= meta_s4;

			meta_s6 <= meta_s5;
			meta_s7 <= meta_s6;
		end
	end

	// Stage 6: corners rounded to Q.4 and clipped to the image.
	logic [COORD_W-1:0] bound_x, bound_y;
	logic [COORD_W-1:0] x0_s6, x1_s6, y0_s6, y1_s6;

	assign bound_x = clip_bound(image_width_q);
	assign bound_y = clip_bound(image_height_q);

	abdc_clip u_clip_x (.clk(clk), .en(en), .c(cx_s5), .h(hw_s5), .bound(bound_x),
		.lo(x0_s6), .hi(x1_s6));
	abdc_clip u_clip_y (.clk(clk), .en(en), .c(cy_s5), .h(hh_s5), .bound(bound_y),
		.lo(y0_s6), .hi(y1_s6));

	// Stage 7: size test and the output register.
	logic signed [18:0]  wid, hgt, mbs;
	logic [COORD_W-1:0]  x0_s7, x1_s7, y0_s7, y1_s7;
	logic                keep_s7;

	assign wid = signed'({2'b0, x1_s6}) - signed'({2'b0, x0_s6}) + 19'sd16;
	assign hgt = signed'({2'b0, y1_s6}) - signed'({2'b0, y0_s6}) + 19'sd16;
	assign mbs = signed'({2'b0, min_box_size_q});

	always_ff @(posedge clk) begin
		if (en) begin
			x0_s7   <= x0_s6;
			x1_s7   <= x1_s6;
			y0_s7   <= y0_s6;
			y1_s7   <= y1_s6;
			keep_s7 <= (wid >= mbs) && (hgt >= mbs);
		end
	end

	assign box.valid      = v_s7;
	assign box.box_left   = x0_s7;
	assign box.box_top    = y0_s7;
	assign box.box_right  = x1_s7;
	assign box.box_bottom = y1_s7;
	assign box.score_out  = meta_s7.score;
	assign box.keep       = keep_s7;
	assign box.last_out   = meta_s7.last;

endmodule

[rtl/abdc_checker.sv]
// ----------------------------------------------------------------------------
// abdc_checker: port-level checks of the anchor box decoder
// Watches the two channels and flags stalls or drops that break the pipeline.
// ----------------------------------------------------------------------------
module abdc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [16:0] out_left,
	input logic [16:0] out_right,
	input logic [15:0] out_score,
	input logic        out_keep,
	input logic        out_last
);

	// A box that waits stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("box transaction withdrawn while stalled");

	// A waiting box does not change.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_left) && $stable(out_right) &&
		$stable(out_score) && $stable(out_keep) && $stable(out_last))
		else $error("box payload changed while stalled");

	// With the output stage empty the pipeline must take a proposal.
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("proposal refused with empty output stage");

	// A box leaving frees a slot, so input is accepted in the same cycle.
	a_drain_ready: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |-> in_ready)
		else $error("proposal refused while a box transaction completes");

	// The pipeline only stalls while a box waits.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |-> out_valid && !out_ready)
		else $error("proposal stalled without a waiting box");

endmodule

bind anchor_box_decode_clip abdc_checker u_abdc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (proposal.valid),
	.in_ready  (proposal.ready),
	.out_valid (box.valid),
	.out_ready (box.ready),
	.out_left  (box.box_left),
	.out_right (box.box_right),
	.out_score (box.score_out),
	.out_keep  (box.keep),
	.out_last  (box.last_out)
);

[sim/anchor_box_decode_clip_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// anchor_box_decode_clip_tb: self-checking bench for the anchor box decoder
// Streams directed and random proposals through the block under several
// register settings, predicts or looks up every decoded box, and compares the boxes in
// order with random stalls on both channels.
// ----------------------------------------------------------------------------
module anchor_box_decode_clip_tb;
	import abdc_pkg::*;

	typedef struct {
		logic signed [19:0] left, top, right, bottom;
		logic [9:0]         col, row;
		logic [15:0]        score;
		logic signed [15:0] dx, dy, dw, dh;
		logic               last;
	} proposal_t;

	typedef struct {
		logic [16:0] left, top, right, bottom;
		logic [15:0] score;
		logic        keep;
		logic        last;
	} box_t;

	// One row of the directed table; the box is typed in only where it is obvious.
	typedef struct {
		proposal_t prop;
		bit        typed;
		box_t      box;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	abdc_in_if  prop_if ();
	abdc_out_if box_if ();

	anchor_box_decode_clip i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.proposal  (prop_if.sink),
		.box       (box_if.source)
	);

	// Local copy of the registers, updated when a write lands.
	logic [13:0] img_height, img_width;
	logic [16:0] min_box_q4;
	logic [6:0]  stride;

	// Mantissa table 2^(i/64) in Q.16, built here from the same series.
	longint pow2_q16 [0:EXP_TAB_SIZE];

	box_t      expected_boxes [$];
	dir_row_t  dir_rows [$];
	int        n_sent, n_boxes, n_mismatch, n_kept;
	bit        quiet_sender, quiet_receiver;
	int        stall_left;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// The exponential and the geometry in plain 64-bit integers. Arithmetic right
	// shifts of signed values floor, which is what the fixed-point scheme needs.
	function automatic longint exp_q16(longint d);
		longint y, k, f, idx, rem, m, r;
		y = (d * 23637) >>> 10;
		k = y >>> 16;
		f = y - k * 65536;
		idx = f >> EXP_LOW_BITS;
		rem = f & ((64'sd1 << EXP_LOW_BITS) - 1);
		m = pow2_q16[idx] + (((pow2_q16[idx + 1] - pow2_q16[idx]) * rem) >>> EXP_LOW_BITS);
		if (k < 0) begin
			r = (k <= -40) ? 0 : (m >>> (-k));
		end else if (k > 20) begin
			r = 64'sd268435455;
		end else begin
			r = m << k;
		end
		if (r > 64'sd268435455) r = 64'sd268435455;
		return r;
	endfunction

	function automatic longint bound_q4(logic [13:0] size);
		longint b;
		b = (size == 0) ? 0 : (longint'(size) - 1) * 16;
		return (b > 131071) ? 131071 : b;
	endfunction

	function automatic longint round_clip(longint v21, longint bound);
		longint q;
		q = (v21 + 65536) >>> 17;
		if (q < 0) q = 0;
		if (q > bound) q = bound;
		return q;
	endfunction

	function automatic box_t decode_proposal(proposal_t p);
		box_t   o;
		longint aw, ah, ax, ay, cx, cy, hw, hh, s16, bx, by, x0, y0, x1, y1;
		s16 = longint'(stride) * 16;
		aw = longint'(p.right) - longint'(p.left) + 16;
		ah = longint'(p.bottom) - longint'(p.top) + 16;
		ax = longint'(p.left) + longint'(p.col & GRID_MASK) * s16;
		ay = longint'(p.top) + longint'(p.row & GRID_MASK) * s16;
		cx = (2 * ax + aw - 16) * 65536 + aw * longint'(p.dx) * 32;
		cy = (2 * ay + ah - 16) * 65536 + ah * longint'(p.dy) * 32;
		hw = aw * exp_q16(longint'(p.dw)) - 1048576;
		hh = ah * exp_q16(longint'(p.dh)) - 1048576;
		bx = bound_q4(img_width);
		by = bound_q4(img_height);
		x0 = round_clip(cx - hw, bx);
		y0 = round_clip(cy - hh, by);
		x1 = round_clip(cx + hw, bx);
		y1 = round_clip(cy + hh, by);
		o.left = x0[16:0];
		o.top = y0[16:0];
		o.right = x1[16:0];
		o.bottom = y1[16:0];
		o.score = p.score;
		o.keep = (x1 - x0 + 16 >= longint'(min_box_q4)) &&
			(y1 - y0 + 16 >= longint'(min_box_q4));
		o.last = p.last;
		return o;
	endfunction

	// Mostly no gap, often a short one, now and then a long one; none at all in quiet stretches.
	function automatic int idle_len(bit quiet);
		if (quiet) return 0;
		if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
		if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
		return 0;
	endfunction

	function automatic proposal_t make_prop(int l, int t, int r, int b, int col, int row,
			int dx, int dy, int dw, int dh);
		proposal_t p;
		p.left = 20'(l);
		p.top = 20'(t);
		p.right = 20'(r);
		p.bottom = 20'(b);
		p.col = 10'(col);
		p.row = 10'(row);
		p.score = 16'($urandom);
		p.dx = 16'(dx);
		p.dy = 16'(dy);
		p.dw = 16'(dw);
		p.dh = 16'(dh);
		p.last = 1'($urandom_range(0, 1));
		return p;
	endfunction

	// Random proposal: a typical anchor and small deltas most of the time, raw
	// random bits in every field otherwise so that each bit toggles.
	function automatic proposal_t random_prop();
		proposal_t p;
		int half_w, half_h, cxv, cyv;
		if ($urandom_range(0, 4) == 0) begin
			p.left = 20'($urandom);
			p.top = 20'($urandom);
			p.right = 20'($urandom);
			p.bottom = 20'($urandom);
			p.col = 10'($urandom);
			p.row = 10'($urandom);
			p.dx = 16'($urandom);
			p.dy = 16'($urandom);
			p.dw = 16'($urandom);
			p.dh = 16'($urandom);
			p.score = 16'($urandom);
			p.last = 1'($urandom_range(0, 1));
		end else begin
			half_w = $urandom_range(8, 4096);
			half_h = $urandom_range(8, 4096);
			cxv = $urandom_range(0, 256) - 128;
			cyv = $urandom_range(0, 256) - 128;
			p = make_prop(cxv - half_w, cyv - half_h, cxv + half_w, cyv + half_h,
				$urandom_range(0, 80), $urandom_range(0, 80),
				$urandom_range(0, 4096) - 2048, $urandom_range(0, 4096) - 2048,
				$urandom_range(0, 8192) - 4096, $urandom_range(0, 8192) - 4096);
		end
		return p;
	endfunction

	// One transaction on the proposal channel, followed by a random pause. The
	// expected box is queued at the accepting edge, with the registers in force.
	task automatic send_proposal(proposal_t p, bit typed, box_t typed_box);
		int gap;
		@(negedge clk);
		prop_if.valid <= 1'b1;
		prop_if.anchor_left <= p.left;
		prop_if.anchor_top <= p.top;
		prop_if.anchor_right <= p.right;
		prop_if.anchor_bottom <= p.bottom;
		prop_if.grid_col <= p.col;
		prop_if.grid_row <= p.row;
		prop_if.objectness <= p.score;
		prop_if.delta_x <= p.dx;
		prop_if.delta_y <= p.dy;
		prop_if.delta_w <= p.dw;
		prop_if.delta_h <= p.dh;
		prop_if.last_in <= p.last;
		do @(posedge clk); while (!prop_if.ready);
		expected_boxes.push_back(typed ? typed_box : decode_proposal(p));
		n_sent++;
		gap = idle_len(quiet_sender);
		if (gap > 0) begin
			@(negedge clk);
			prop_if.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic drop_valid_and_drain();
		@(negedge clk);
		prop_if.valid <= 1'b0;
		wait (expected_boxes.size() == 0);
		repeat (12) @(posedge clk);
	endtask

	// Register writes happen only with the pipeline empty.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= CFG_DATA_W'(value);
		@(posedge clk);
		case (idx)
			REG_IMAGE_HEIGHT:   img_height = 14'(value);
			REG_IMAGE_WIDTH:    img_width = 14'(value);
			REG_MIN_BOX_SIZE:   min_box_q4 = 17'(value);
			REG_FEATURE_STRIDE: stride = 7'(value);
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_regs(int h, int w, int mb, int s);
		drop_valid_and_drain();
		write_reg(REG_IMAGE_HEIGHT, h);
		write_reg(REG_IMAGE_WIDTH, w);
		write_reg(REG_MIN_BOX_SIZE, mb);
		write_reg(REG_FEATURE_STRIDE, s);
	endtask

	task automatic add_row(proposal_t p, bit typed, box_t b);
		dir_row_t row;
		row.prop = p;
		row.typed = typed;
		row.box = b;
		dir_rows.push_back(row);
	endtask

	// Receiver: stalls of random length driven at the falling edge.
	always @(negedge clk) begin
		int g;
		if (quiet_receiver) begin
			stall_left = 0;
			box_if.ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			box_if.ready <= 1'b0;
		end else begin
			g = idle_len(1'b0);
			if (g > 0) begin
				stall_left = g - 1;
				box_if.ready <= 1'b0;
			end else begin
				box_if.ready <= 1'b1;
			end
		end
	end

	// Checker: each box is compared field by field with the oldest expectation.
	always @(posedge clk) begin
		box_t want;
		if (arst_n && box_if.valid && box_if.ready) begin
			n_boxes++;
			if (expected_boxes.size() == 0) begin
				n_mismatch++;
				if (n_mismatch <= 10) $display("ERROR: box with no proposal outstanding");
			end else begin
				want = expected_boxes.pop_front();
				if (box_if.keep) n_kept++;
				if (box_if.box_left !== want.left || box_if.box_top !== want.top ||
						box_if.box_right !== want.right || box_if.box_bottom !== want.bottom ||
						box_if.score_out !== want.score || box_if.keep !== want.keep ||
						box_if.last_out !== want.last) begin
					n_mismatch++;
					if (n_mismatch <= 10) begin
						$display("ERROR: box %0d expected l=%0d t=%0d r=%0d b=%0d s=%0d k=%0d last=%0d",
							n_boxes, want.left, want.top, want.right, want.bottom, want.score,
							want.keep, want.last);
						$display("       actual        l=%0d t=%0d r=%0d b=%0d s=%0d k=%0d last=%0d",
							box_if.box_left, box_if.box_top, box_if.box_right, box_if.box_bottom,
							box_if.score_out, box_if.keep, box_if.last_out);
					end
				end
			end
		end
	end

	initial begin
		#5ms;
		$display("ERROR: timeout with %0d boxes outstanding", expected_boxes.size());
		$display("anchor_box_decode_clip verification failed");
		$finish;
	end

	initial begin
		longint unsigned z, term, sum;
		proposal_t p;
		box_t      b;
		int        phase;

		for (int i = 0; i <= EXP_TAB_SIZE; i++) begin
			z = (longint'(i) * 64'd744261118) >> EXP_TABLE_BITS;
			term = 64'd1 << 30;
			sum = term;
			for (int n = 1; n <= 13; n++) begin
				term = ((term * z) >> 30) / longint'(n);
				sum += term;
			end
			pow2_q16[i] = longint'((sum + (64'd1 << 13)) >> 14);
		end

		n_sent = 0;
		n_boxes = 0;
		n_mismatch = 0;
		n_kept = 0;
		stall_left = 0;
		quiet_sender = 1'b0;
		quiet_receiver = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = REG_IMAGE_HEIGHT;
		cfg_wdata = '0;
		prop_if.valid = 1'b0;
		prop_if.anchor_left = '0;
		prop_if.anchor_top = '0;
		prop_if.anchor_right = '0;
		prop_if.anchor_bottom = '0;
		prop_if.grid_col = '0;
		prop_if.grid_row = '0;
		prop_if.objectness = '0;
		prop_if.delta_x = '0;
		prop_if.delta_y = '0;
		prop_if.delta_w = '0;
		prop_if.delta_h = '0;
		prop_if.last_in = 1'b0;
		img_height = 14'd1024;
		img_width = 14'd1024;
		min_box_q4 = 17'd256;
		stride = 7'd16;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed rows under the reset registers. A point anchor with zero deltas
		// decodes to a point at the origin that is too small to keep.
		p = make_prop(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		b = '{left: 0, top: 0, right: 0, bottom: 0, score: p.score, keep: 0, last: p.last};
		add_row(p, 1, b);
		// An anchor far off to the upper left clips to the origin.
		p = make_prop(-524288, -524288, -524000, -524000, 0, 0, 0, 0, 0, 0);
		b = '{left: 0, top: 0, right: 0, bottom: 0, score: p.score, keep: 0, last: p.last};
		add_row(p, 1, b);
		// The largest log scale gives a factor near e to the eighth, so the box
		// spans the whole image.
		p = make_prop(0, 0, 0, 0, 0, 0, 0, 0, 32767, 32767);
		b = '{left: 0, top: 0, right: 16368, bottom: 16368, score: p.score, keep: 1,
			last: p.last};
		add_row(p, 1, b);
		// Field extremes, inverted anchors, grid corners and the smallest scale.
		add_row(make_prop(524287, 524287, 524287, 524287, 1023, 1023, 32767, 32767, 0, 0),
			0, b);
		add_row(make_prop(-524288, -524288, 524287, 524287, 0, 0, -32768, -32768, -32768,
			-32768), 0, b);
		add_row(make_prop(4096, 4096, -4096, -4096, 5, 7, 0, 0, 1000, -1000), 0, b);
		add_row(make_prop(-128, -128, 127, 127, 1023, 0, 2048, -2048, 4096, 4096), 0, b);
		add_row(make_prop(-2048, -1024, 2047, 1023, 0, 1023, -4096, 4096, -4096, 2048), 0, b);
		add_row(make_prop(100, 200, 300, 400, 31, 31, 1, -1, 1, -1), 0, b);
		add_row(make_prop(0, 0, 255, 255, 512, 512, 32767, -32768, 32767, -32768), 0, b);
		foreach (dir_rows[i]) send_proposal(dir_rows[i].prop, dir_rows[i].typed, dir_rows[i].box);

		// Extremes of the registers, then random settings. Zero image sizes, an
		// oversized image and a zero stride each get a pass of random proposals.
		for (phase = 0; phase < 8; phase++) begin
			case (phase)
				0: set_regs(1, 1, 0, 1);
				1: set_regs(8192, 8192, 131071, 64);
				2: set_regs(0, 16383, 16, 0);
				3: set_regs(16383, 0, 1, 127);
				4: set_regs(600, 1000, 256, 16);
				default: set_regs($urandom_range(1, 8192), $urandom_range(1, 8192),
					$urandom_range(0, 2000), $urandom_range(1, 64));
			endcase
			quiet_sender = (phase == 4);
			quiet_receiver = (phase == 4) || (phase == 6);
			repeat (80) send_proposal(random_prop(), 0, b);
			if (phase == 5) begin
				// Let the pipeline empty completely, then burst again.
				drop_valid_and_drain();
				repeat (20) send_proposal(random_prop(), 0, b);
			end
		end

		@(negedge clk);
		prop_if.valid <= 1'b0;
		wait (expected_boxes.size() == 0);
		repeat (20) @(posedge clk);
		$display("Decoded %0d proposals into %0d boxes (%0d kept) over nine register settings,",
			n_sent, n_boxes, n_kept);
		$display("with field extremes, large scales and random stalls on both channels.");
		if (n_mismatch == 0) begin
			$display("anchor_box_decode_clip verification clean");
		end else begin
			$display("%0d mismatches in total", n_mismatch);
			$display("anchor_box_decode_clip verification failed");
		end
		$finish;
	end

endmodule
